FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files of the ordered key list engine.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, disabled while reset is applied.
`define OKLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on the rising clock edge, disabled while reset is applied.
`define OKLE_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

FILE: rtl/okle_pkg.sv
// Package for the ordered key list engine: field widths, command codes and
// sequencer state type. No dependencies.
package okle_pkg;

  localparam int CMD_W = 3;
  localparam int KEY_W = 32;
  localparam int POS_W = 7;
  localparam int IDX_W = 6;
  localparam int LEN_W = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_UP,
    ST_PUT,
    ST_SCAN,
    ST_SHIFT_DN,
    ST_HEAD,
    ST_RESP
  } state_e;

endpackage

FILE: rtl/okle_cmd_if.sv
// Command channel of the ordered key list engine: valid/ready plus command word.
// Depends on okle_pkg.
interface okle_cmd_if;
  import okle_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [KEY_W-1:0] key;
  logic [POS_W-1:0]        position;

  modport source (output valid, command, key, position, input ready);
  modport sink   (input valid, command, key, position, output ready);
endinterface

FILE: rtl/okle_res_if.sv
// Result channel of the ordered key list engine: valid/ready plus result word.
// Depends on okle_pkg.
interface okle_res_if;
  import okle_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    ok;
  logic [IDX_W-1:0]        found_index;
  logic [LEN_W-1:0]        match_count;
  logic [LEN_W-1:0]        list_length;
  logic signed [KEY_W-1:0] first_key;
  logic                    first_present;

  modport source (output valid, ok, found_index, match_count, list_length, first_key,
                  first_present, input ready);
  modport sink   (input valid, ok, found_index, match_count, list_length, first_key,
                  first_present, output ready);
endinterface

FILE: rtl/okle_mem.sv
// Entry store of the ordered key list engine: one write port, one read port,
// registered read data. No dependencies.
module okle_mem #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ordered_key_list_engine_core.sv
// Top level of the ordered key list engine: command sequencer, length register
// and result word. Depends on okle_pkg, okle_cmd_if, okle_res_if, okle_mem and
// assert_macros.svh.
//
// The engine keeps an ordered list of up to CAPACITY signed 32-bit keys in a
// single-port-read, single-port-write memory and takes one command word at a
// time; ready is low from acceptance until the result word is taken. Every
// memory access of a command goes through the one read port, one entry per
// cycle, so the time a command takes follows the walk it makes: insert walks
// from the end of the list down to its position, search and delete walk up to
// the match or over the whole list when the key is absent, delete then shifts
// the entries above the match down, count walks the whole list, and clear,
// unknown codes and a refused insert walk nothing. No clearing pass follows
// reset.
`include "assert_macros.svh"

module ordered_key_list_engine_core #(
  parameter int CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  okle_cmd_if.sink   cmd_i,
  okle_res_if.source res_o
);
  import okle_pkg::*;

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  state_e             state_q, state_d;
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   rd_q, rd_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [ADDR_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic               wr_pend_q, wr_pend_d;
  logic [ADDR_W-1:0]  wr_addr_q, wr_addr_d;
  logic               ok_q, ok_d;
  logic [ADDR_W-1:0]  found_q, found_d;
  logic [CNT_W-1:0]   match_q, match_d;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [KEY_W-1:0]   mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [KEY_W-1:0]   mem_rdata;

  logic accept;
  logic ins_ok;
  logic up_more;
  logic dn_more;
  logic hit;

  okle_mem #(
    .DEPTH  (CAPACITY),
    .WIDTH  (KEY_W),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign accept  = cmd_i.valid && cmd_i.ready;
  assign ins_ok  = (cnt_q < CNT_W'(CAPACITY)) &&
                   (CMP_W'(cmd_i.position) <= CMP_W'(cnt_q));
  assign up_more = CMP_W'(rd_q) > CMP_W'(pos_q);
  assign dn_more = rd_q < cnt_q;
  assign hit     = cmp_vld_q && (mem_rdata == key_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i.command) inside
            CMD_INSERT:                       state_d = ins_ok ? ST_SHIFT_UP : ST_HEAD;
            CMD_DELETE, CMD_SEARCH, CMD_COUNT: state_d = ST_SCAN;
            default:                          state_d = ST_HEAD;
          endcase
        end
      end
      ST_SHIFT_UP: begin
        if (!up_more) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: state_d = ST_HEAD;
      ST_SCAN: begin
        if (hit && cmd_q == CMD_DELETE) begin
          state_d = ST_SHIFT_DN;
        end else if (hit && cmd_q == CMD_SEARCH) begin
          state_d = ST_HEAD;
        end else if (!dn_more && !cmp_vld_q) begin
          state_d = ST_HEAD;
        end
      end
      ST_SHIFT_DN: begin
        if (!dn_more) begin
          state_d = ST_HEAD;
        end
      end
      ST_HEAD: state_d = ST_RESP;
      ST_RESP: begin
        if (res_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_d     = cmd_q;
    key_d     = key_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    rd_d      = rd_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;
    wr_pend_d = wr_pend_q;
    wr_addr_d = wr_addr_q;
    ok_d      = ok_q;
    found_d   = found_q;
    match_d   = match_q;
    mem_we    = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d     = cmd_i.command;
          key_d     = cmd_i.key;
          pos_d     = cmd_i.position;
          ok_d      = 1'b0;
          found_d   = '0;
          match_d   = '0;
          cmp_vld_d = 1'b0;
          wr_pend_d = 1'b0;
          rd_d      = (cmd_i.command == CMD_INSERT) ? cnt_q : '0;
          if (cmd_i.command == CMD_CLEAR) begin
            cnt_d = '0;
          end
        end
      end
      ST_SHIFT_UP: begin
        if (up_more) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(rd_q - 1'b1);
          rd_d      = rd_q - 1'b1;
        end
        mem_we    = wr_pend_q;
        wr_pend_d = up_more;
        wr_addr_d = ADDR_W'(rd_q);
      end
      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(pos_q);
        mem_wdata = key_q;
        cnt_d     = cnt_q + 1'b1;
        ok_d      = 1'b1;
      end
      ST_SCAN: begin
        if (hit && cmd_q != CMD_COUNT) begin
          ok_d      = 1'b1;
          found_d   = cmp_idx_q;
          rd_d      = CNT_W'(cmp_idx_q) + 1'b1;
          cmp_vld_d = 1'b0;
          wr_pend_d = 1'b0;
        end else begin
          if (dn_more) begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(rd_q);
            rd_d      = rd_q + 1'b1;
          end
          cmp_vld_d = dn_more;
          cmp_idx_d = ADDR_W'(rd_q);
          if (hit) begin
            match_d = match_q + 1'b1;
          end
        end
      end
      ST_SHIFT_DN: begin
        if (dn_more) begin
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(rd_q);
          rd_d      = rd_q + 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
        mem_we    = wr_pend_q;
        wr_pend_d = dn_more;
        wr_addr_d = ADDR_W'(rd_q - 1'b1);
      end
      ST_HEAD: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cmp_vld_q <= cmp_vld_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    pos_q     <= pos_d;
    rd_q      <= rd_d;
    cmp_idx_q <= cmp_idx_d;
    wr_addr_q <= wr_addr_d;
    ok_q      <= ok_d;
    found_q   <= found_d;
    match_q   <= match_d;
  end

  assign cmd_i.ready         = (state_q == ST_IDLE);
  assign res_o.valid         = (state_q == ST_RESP);
  assign res_o.ok            = ok_q;
  assign res_o.found_index   = IDX_W'(found_q);
  assign res_o.match_count   = LEN_W'(match_q);
  assign res_o.list_length   = LEN_W'(cnt_q);
  assign res_o.first_present = (cnt_q != '0);
  assign res_o.first_key     = (cnt_q != '0) ? mem_rdata : '0;

  `OKLE_ASSERT(a_len_bound, cnt_q <= CNT_W'(CAPACITY), "list length exceeds capacity")
  `OKLE_ASSERT_IMPL(a_no_overlap, res_o.valid, !cmd_i.ready, "ready while result pending")
  `OKLE_ASSERT_IMPL(a_put_grows, state_q == ST_PUT, ##1 cnt_q == $past(cnt_q) + 1'b1,
                    "insert did not grow the list")
  `OKLE_ASSERT_IMPL(a_count_no_ok, res_o.valid && cmd_q == CMD_COUNT, !res_o.ok,
                    "count reported ok")

endmodule
